// ===== sv/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg: shared types and codes for the byte ring FIFO
// Word layouts for the command and result ports, operation and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  // operation codes of an input word
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PUT_REPORT = 2'd0;
  localparam logic [1:0] KIND_READ_BYTE  = 2'd1;
  localparam logic [1:0] KIND_GET_EMPTY  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] data_in;
    logic       run_last;
    logic [6:0] want_count;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_out;
    logic [7:0] accepted;
    logic       burst_last;
    logic [7:0] fill_level;
    logic [7:0] free_space;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/byte_ring_fifo_burst.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst: byte ring FIFO with burst reads
// Put runs store one byte per word until the FIFO is full; gets return up to MAX_BURST bytes.
// ----------------------------------------------------------------------------
// Put: busy_o stays low, so puts stream at one per cycle; a run's report
//   appears in the cycle after its last word is taken.
// Get: the first byte passes the RAM read register, then the output
//   register, then one byte follows per cycle; an empty get does not raise
//   busy_o. busy_o is high while a burst drains, and no word is taken then.
// Results are strobed by out_valid_o for one cycle; the receiver cannot stall.
// Reset clears pointers, count and run state at once; RAM contents are left as
//   they are (only written entries are ever read).
`default_nettype none

module byte_ring_fifo_burst #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire brf_pkg::in_t  in_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output brf_pkg::out_t      out_o
);

  import brf_pkg::*;

  localparam int PW = $clog2(DEPTH);            // pointer and count width
  localparam int NW = (PW > 7) ? PW : 7;        // compare width for burst size
  localparam logic [PW-1:0] MAX_FILL  = PW'(DEPTH - 1);
  localparam logic [6:0]    BURST_MAX = 7'(MAX_BURST);

  typedef enum logic {
    ST_IDLE,
    ST_GET
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [7:0]    run_acc_q, run_acc_d;
  logic          run_ref_q, run_ref_d;
  logic [6:0]    rem_q, rem_d;          // bytes still to emit in a burst
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  // RAM ports
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  logic          accept;
  logic          put_store;
  logic [6:0]    want_clamped;
  logic [NW-1:0] burst_n;

  assign accept = start_i && (state_q == ST_IDLE);

  // zero means one, above the limit means the limit
  always_comb begin
    if (in_i.want_count == 7'd0) begin
      want_clamped = 7'd1;
    end else if (in_i.want_count > BURST_MAX) begin
      want_clamped = BURST_MAX;
    end else begin
      want_clamped = in_i.want_count;
    end
  end

  // min(request, level); a burst never exceeds MAX_BURST so fits 7 bits
  assign burst_n = (NW'(want_clamped) < NW'(fill_q)) ? NW'(want_clamped) : NW'(fill_q);

  assign put_store = accept && (in_i.op == OP_PUT) && !run_ref_q && (fill_q != MAX_FILL);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == MAX_FILL) ? '0 : p + PW'(1);
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    run_acc_d   = run_acc_q;
    run_ref_d   = run_ref_q;
    rem_d       = rem_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.op == OP_PUT) begin
          if (put_store) begin
            ram_we   = 1'b1;
            wr_ptr_d = next_slot(wr_ptr_q);
            fill_d   = fill_q + PW'(1);
            if (run_acc_q != 8'hFF) begin
              run_acc_d = run_acc_q + 8'd1;
            end
          end else begin
            run_ref_d = 1'b1;
          end
          if (in_i.run_last) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_PUT_REPORT;
            out_d.data_out   = 8'd0;
            out_d.accepted   = put_store && (run_acc_q != 8'hFF) ? run_acc_q + 8'd1
                                                                  : run_acc_q;
            out_d.burst_last = 1'b1;
            run_acc_d        = 8'd0;
            run_ref_d        = 1'b0;
          end
        end else if (accept) begin
          if (fill_q == '0) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_GET_EMPTY;
            out_d.data_out   = 8'd0;
            out_d.accepted   = 8'd0;
            out_d.burst_last = 1'b1;
          end else begin
            // first read goes out now, data arrives in ST_GET
            ram_re   = 1'b1;
            rd_ptr_d = next_slot(rd_ptr_q);
            rem_d    = burst_n[6:0];
            state_d  = ST_GET;
          end
        end
      end
      ST_GET: begin
        out_valid_d      = 1'b1;
        out_d.kind       = KIND_READ_BYTE;
        out_d.data_out   = ram_rdata;
        out_d.accepted   = 8'd0;
        out_d.burst_last = (rem_q == 7'd1);
        fill_d           = fill_q - PW'(1);
        rem_d            = rem_q - 7'd1;
        if (rem_q == 7'd1) begin
          state_d = ST_IDLE;
        end else begin
          ram_re   = 1'b1;
          rd_ptr_d = next_slot(rd_ptr_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // level and space after this result
    out_d.fill_level = 8'(fill_d);
    out_d.free_space = 8'(MAX_FILL - fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      run_acc_q   <= 8'd0;
      run_ref_q   <= 1'b0;
      rem_q       <= 7'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      run_acc_q   <= run_acc_d;
      run_ref_q   <= run_ref_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // byte store: written by puts, read by gets (never in the same cycle)
  brf_ram #(
    .Width(8),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(in_i.data_in),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign busy_o      = (state_q == ST_GET);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // level and space always add up to the usable depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (8'(out_q.fill_level + out_q.free_space) == 8'(DEPTH - 1)))
    else $error("level and free space disagree");

  // one slot is always kept empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MAX_FILL)
    else $error("fill count beyond capacity");

  // a burst in progress has bytes left and bytes held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GET) |-> (rem_q != 7'd0) && (fill_q != '0))
    else $error("burst without data");

  // a get on an empty FIFO answers next cycle with one final empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OP_GET && fill_q == '0) |=>
      out_valid_q && (out_q.kind == KIND_GET_EMPTY) && out_q.burst_last && !busy_o)
    else $error("empty get not reported");

  // every burst ends with a final-marked byte as it leaves the get state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GET && rem_q == 7'd1) |=> out_q.burst_last && (state_q == ST_IDLE))
    else $error("burst end not marked");

endmodule

`default_nettype wire
